@@ rtl/mlnd_pkg.sv @@
// ----------------------------------------------------------------------------
// mlnd_pkg - shared types and constants
// Codes, configuration layout and divider handshake for the MIDI list
// navigation decoder.
// ----------------------------------------------------------------------------
package mlnd_pkg;

	localparam int SLOT_COUNT = 4;
	localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	localparam int DIV_STEPS  = 16;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	localparam logic [3:0]  MSG_NOTE_ON   = 4'h9;
	localparam logic [3:0]  MSG_CONTROL   = 4'hB;
	localparam logic [4:0]  CHAN_ANY      = 5'd16;
	localparam logic [7:0]  UNDEF_CODE    = 8'hFF;
	localparam logic [7:0]  HALF_VALUE    = 8'd64;
	localparam logic [15:0] DIAL_SPAN     = 16'd127;
	localparam logic [16:0] INDEX_DIVISOR = 17'd3;

	// value / 3 as (value * 43) >> 7, exact for 7-bit values
	localparam logic [12:0] THIRD_RECIP   = 13'd43;
	localparam int          THIRD_SHIFT   = 7;

	typedef enum logic [2:0] {
		REG_NOTE_CHANNEL       = 3'd0,
		REG_CONTROLLER_CHANNEL = 3'd1,
		REG_KEY_MAP            = 3'd2,
		REG_SLOT_ZERO          = 3'd3,
		REG_SLOT_ONE           = 3'd4,
		REG_SLOT_TWO           = 3'd5,
		REG_SLOT_THREE         = 3'd6,
		REG_NOTES_MUTED        = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ROLE_NONE   = 2'd0,
		ROLE_SELECT = 2'd1,
		ROLE_PAGE   = 2'd2,
		ROLE_INDEX  = 2'd3
	} role_t;

	typedef enum logic [2:0] {
		KIND_UNKNOWN    = 3'd0,
		KIND_TOGGLE     = 3'd1,
		KIND_MOMENTARY  = 3'd2,
		KIND_CONTINUOUS = 3'd3,
		KIND_ENDLESS    = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_SEND = 2'd1,
		ACT_SET  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		OP_JUMP  = 2'd0,
		OP_FIRST = 2'd1,
		OP_PAGE  = 2'd2,
		OP_INDEX = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DIV_MAXP,
		ST_DIV_STEP,
		ST_DIV_VAL,
		ST_DIV_IDX,
		ST_MUL,
		ST_CAND,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [7:0] base;
		logic [2:0] kind;
		logic [1:0] role;
		logic [7:0] number;
	} slot_t;

	typedef struct packed {
		logic [4:0]                   note_channel;
		logic [4:0]                   controller_channel;
		logic [47:0]                  key_map;
		slot_t [SLOT_COUNT-1:0]       slots;
		logic                         notes_muted;
		logic                         key_ok;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic [15:0] dividend;
		logic [16:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] quotient;
		logic [16:0] remainder;
	} div_rsp_t;

endpackage

@@ rtl/mlnd_if.sv @@
// ----------------------------------------------------------------------------
// mlnd_if - channel interfaces
// Valid/ready channels for MIDI items, navigation results and register writes.
// ----------------------------------------------------------------------------
interface mlnd_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  status_byte;
	logic [6:0]  data_one;
	logic [6:0]  data_two;
	logic [15:0] current_position;
	logic [15:0] list_length;
	logic [7:0]  entries_per_page;

	modport source (output valid, status_byte, data_one, data_two, current_position,
		list_length, entries_per_page, input ready);
	modport sink (input valid, status_byte, data_one, data_two, current_position,
		list_length, entries_per_page, output ready);
endinterface

interface mlnd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [15:0] new_position;
	logic        paging_mode;

	modport source (output valid, action, new_position, paging_mode, input ready);
	modport sink (input valid, action, new_position, paging_mode, output ready);
endinterface

interface mlnd_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [47:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/midi_list_navigation_decoder_core.sv @@
// ----------------------------------------------------------------------------
// midi_list_navigation_decoder_core - MIDI list navigation decoder
// Turns note-on and controller messages into list navigation actions.
// ----------------------------------------------------------------------------
// in_ch takes one MIDI message per item with the list's current index,
// length and page size; out_ch returns exactly one result per item: action
// (none, send, set index), the new index and the paging mode after the item.
// cfg_ch writes the eight registers by index; it is always ready and should
// only be used while no item is in flight.
// Messages decided at decode (keys, select controllers, no match) and index
// controllers use no division; page steps and first-key entry picks divide
// once (a step back from the first page ends before the candidate state),
// and a page controller divides four times (twice when the list is shorter
// than one page). All divisions run on the shared 16-step restoring divider,
// which is used up to four times per item.
// in_ch is ready only while the sequencer is idle; one item is in work at a
// time and the next one is taken the cycle after the result is loaded.
// A finished result sits in the output register; if the receiver stalls,
// the sequencer waits with the next result and takes no new item.
// Reset clears the configuration to its defaults, entry stepping mode,
// the dial page and the select controllers' last values.
// ----------------------------------------------------------------------------
module midi_list_navigation_decoder_core import mlnd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	mlnd_in_if.sink    in_ch,
	mlnd_out_if.source out_ch,
	mlnd_cfg_if.sink   cfg_ch
);

	cfg_t     cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;

	mlnd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.cfg    (cfg)
	);

	mlnd_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.cfg     (cfg),
		.div_req (div_req),
		.div_rsp (div_rsp)
	);

	mlnd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

@@ rtl/mlnd_div.sv @@
// ----------------------------------------------------------------------------
// mlnd_div - shared restoring divider
// One quotient bit per cycle; 16-bit dividend, 17-bit divisor.
// ----------------------------------------------------------------------------
module mlnd_div import mlnd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [15:0]          quo_q;
	logic [16:0]          rem_q;
	logic [16:0]          dvs_q;

	logic        start;
	logic [17:0] trial;
	logic [17:0] diff;
	logic        fits;

	assign start = req.start && !busy_q && !done_q;
	assign trial = {rem_q, quo_q[15]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cnt_q <= '0;
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
			quo_q <= {quo_q[14:0], fits};
			rem_q <= fits ? diff[16:0] : trial[16:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

@@ rtl/mlnd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// mlnd_cfg_regs - configuration register file
// Holds channels, key map and controller slots; checks the key map.
// ----------------------------------------------------------------------------
module mlnd_cfg_regs import mlnd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	mlnd_cfg_if.sink        cfg_ch,
	output cfg_t            cfg
);

	logic [4:0]             note_chan_q;
	logic [4:0]             ctrl_chan_q;
	logic [47:0]            key_map_q;
	slot_t [SLOT_COUNT-1:0] slot_q;
	logic                   muted_q;

	logic [2:0] slot_pos;
	logic       key_ok;
	logic [7:0] k_sel;
	logic [7:0] k_prv;
	logic [7:0] k_nxt;
	logic [7:0] k_fst;

	assign cfg_ch.ready = 1'b1;
	assign slot_pos     = cfg_ch.index - REG_SLOT_ZERO;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_chan_q <= CHAN_ANY;
			ctrl_chan_q <= CHAN_ANY;
			key_map_q   <= {6{UNDEF_CODE}};
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_q[i] <= slot_t'(21'd255);
			end
			muted_q     <= 1'b0;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_NOTE_CHANNEL:       note_chan_q <= cfg_ch.data[4:0];
				REG_CONTROLLER_CHANNEL: ctrl_chan_q <= cfg_ch.data[4:0];
				REG_KEY_MAP:            key_map_q   <= cfg_ch.data;
				REG_SLOT_ZERO, REG_SLOT_ONE, REG_SLOT_TWO, REG_SLOT_THREE: begin
					for (int i = 0; i < SLOT_COUNT; i++) begin
						if (slot_pos == 3'(i)) begin
							slot_q[i] <= slot_t'(cfg_ch.data[20:0]);
						end
					end
				end
				REG_NOTES_MUTED:        muted_q     <= cfg_ch.data[0];
				default: ;
			endcase
		end
	end

	assign k_sel = key_map_q[7:0];
	assign k_prv = key_map_q[31:24];
	assign k_nxt = key_map_q[39:32];
	assign k_fst = key_map_q[47:40];

	// first key must sit above every other defined key
	always_comb begin
		key_ok = (k_sel != UNDEF_CODE) && (k_prv != k_nxt) &&
			!(k_prv == UNDEF_CODE && k_nxt == UNDEF_CODE && k_fst == UNDEF_CODE);
		if (k_fst != UNDEF_CODE) begin
			for (int k = 0; k < 5; k++) begin
				if (key_map_q[8*k +: 8] != UNDEF_CODE && k_fst <= key_map_q[8*k +: 8]) begin
					key_ok = 1'b0;
				end
			end
		end
	end

	assign cfg.note_channel       = note_chan_q;
	assign cfg.controller_channel = ctrl_chan_q;
	assign cfg.key_map            = key_map_q;
	assign cfg.slots              = slot_q;
	assign cfg.notes_muted        = muted_q;
	assign cfg.key_ok             = key_ok;

endmodule

@@ rtl/mlnd_seq.sv @@
// ----------------------------------------------------------------------------
// mlnd_seq - navigation sequencer
// Decodes one MIDI item, drives the shared divider through the page and
// index arithmetic, and holds the result register.
// ----------------------------------------------------------------------------
module mlnd_seq import mlnd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	mlnd_in_if.sink  in_ch,
	mlnd_out_if.source out_ch,
	input  cfg_t     cfg,
	output div_req_t div_req,
	input  div_rsp_t div_rsp
);

	state_t state_q, state_d;

	// item registers
	logic [7:0]  status_q;
	logic [6:0]  d1_q;
	logic [6:0]  d2_q;
	logic [15:0] idx_q;
	logic [15:0] size_q;
	logic [7:0]  ps_q;

	// navigation state
	logic        flag_q;
	logic [15:0] dial_page_q;
	logic [7:0]  last_q [SLOT_COUNT];

	// working registers
	op_t         op_q;
	logic        dec_q;
	logic [6:0]  inc_q;
	logic [15:0] quo_q;
	logic [7:0]  rem_q;
	logic [15:0] maxp_q;
	logic [6:0]  step_q;
	logic [7:0]  off_q;
	logic [24:0] prod_q;
	action_t     act_q;
	logic [15:0] pos_q;

	// result register
	logic        out_valid_q;
	action_t     out_act_q;
	logic [15:0] out_pos_q;
	logic        out_mode_q;

	// decode
	logic [4:0]        chan;
	logic              note_hit;
	logic              cc_hit;
	logic [7:0]        note;
	logic [7:0]        k_sel, k_page, k_index, k_prv, k_nxt, k_fst;
	logic              is_first;
	logic [7:0]        first_diff;
	logic              idx_inc_ok;
	logic              slot_found;
	logic [SLOT_W-1:0] slot_idx;
	slot_t             cur_slot;
	logic [7:0]        last_val;
	logic              sel_fire;

	// control from the state machine
	logic        fin;
	action_t     fin_act;
	logic [15:0] fin_pos;
	logic        flag_we;
	logic        flag_d;
	logic        last_we;
	logic        op_we;
	op_t         op_d;
	logic        dec_d;
	logic [6:0]  inc_d;
	logic        out_load;

	// datapath
	logic [16:0] mul_a;
	logic [24:0] prod_d;
	logic [7:0]  addend;
	logic [24:0] cand;
	logic [15:0] size_m1;
	logic [7:0]  ps_m1;
	logic [12:0] third_prod;
	logic [7:0]  third;
	logic [7:0]  off_d;

	assign chan     = {1'b0, status_q[3:0]};
	assign note     = {1'b0, d1_q};
	assign k_sel    = cfg.key_map[7:0];
	assign k_page   = cfg.key_map[15:8];
	assign k_index  = cfg.key_map[23:16];
	assign k_prv    = cfg.key_map[31:24];
	assign k_nxt    = cfg.key_map[39:32];
	assign k_fst    = cfg.key_map[47:40];

	assign note_hit = !cfg.notes_muted && status_q[7:4] == MSG_NOTE_ON &&
		(cfg.note_channel == CHAN_ANY || cfg.note_channel == chan) && cfg.key_ok;
	assign cc_hit   = status_q[7:4] == MSG_CONTROL &&
		(cfg.controller_channel == CHAN_ANY || cfg.controller_channel == chan);

	assign is_first   = (k_fst != UNDEF_CODE) && (note >= k_fst);
	assign first_diff = note - k_fst;
	assign idx_inc_ok = ({1'b0, idx_q} + 17'd1) < {1'b0, size_q};

	// lowest numbered matching slot wins
	always_comb begin
		slot_found = 1'b0;
		slot_idx   = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (cfg.slots[i].role != ROLE_NONE && cfg.slots[i].number == note) begin
				slot_found = 1'b1;
				slot_idx   = SLOT_W'(i);
			end
		end
	end

	assign cur_slot = cfg.slots[slot_idx];
	assign last_val = last_q[slot_idx];

	always_comb begin
		case (cur_slot.kind)
			KIND_TOGGLE:     sel_fire = 1'b1;
			KIND_MOMENTARY:  sel_fire = ({1'b0, d2_q} != cur_slot.base);
			KIND_CONTINUOUS,
			KIND_ENDLESS:    sel_fire = (last_val < HALF_VALUE) != ({1'b0, d2_q} < HALF_VALUE);
			default:         sel_fire = 1'b0;
		endcase
	end

	// index controller offset: value / 3, capped to the last entry of a page
	assign third_prod = {6'd0, d2_q} * THIRD_RECIP;
	assign third      = 8'(third_prod >> THIRD_SHIFT);
	assign off_d      = (third > ps_m1) ? ps_m1 : third;

	// multiplier and candidate
	always_comb begin
		case (op_q)
			OP_JUMP:  mul_a = dec_q ? ({1'b0, quo_q} - 17'd1) : ({1'b0, quo_q} + {10'd0, inc_q});
			OP_FIRST: mul_a = {1'b0, quo_q};
			default:  mul_a = {1'b0, dial_page_q};
		endcase
		case (op_q)
			OP_FIRST: addend = {1'b0, inc_q};
			OP_INDEX: addend = off_q;
			default:  addend = rem_q;
		endcase
	end

	assign prod_d  = mul_a * ps_q;
	assign cand    = prod_q + {17'd0, addend};
	assign size_m1 = size_q - 16'd1;
	assign ps_m1   = ps_q - 8'd1;

	always_comb begin
		state_d  = state_q;
		fin      = 1'b0;
		fin_act  = ACT_NONE;
		fin_pos  = '0;
		flag_we  = 1'b0;
		flag_d   = flag_q;
		last_we  = 1'b0;
		op_we    = 1'b0;
		op_d     = op_q;
		dec_d    = 1'b0;
		inc_d    = 7'd1;
		out_load = 1'b0;
		div_req  = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (note_hit) begin
					if (note == k_sel) begin
						fin     = 1'b1;
						fin_act = ACT_SEND;
					end else if (note == k_page) begin
						fin     = 1'b1;
						flag_we = 1'b1;
						flag_d  = (note == k_index || k_index == UNDEF_CODE) ? !flag_q : 1'b1;
					end else if (note == k_index) begin
						fin     = 1'b1;
						flag_we = 1'b1;
						flag_d  = (k_page == UNDEF_CODE) ? !flag_q : 1'b0;
					end else if (note == k_prv) begin
						if (flag_q) begin
							op_we   = 1'b1;
							op_d    = OP_JUMP;
							dec_d   = 1'b1;
							state_d = ST_DIV_IDX;
						end else begin
							fin = 1'b1;
							if (idx_q != 16'd0) begin
								fin_act = ACT_SET;
								fin_pos = idx_q - 16'd1;
							end
						end
					end else if (note == k_nxt) begin
						if (flag_q) begin
							op_we   = 1'b1;
							op_d    = OP_JUMP;
							state_d = ST_DIV_IDX;
						end else begin
							fin = 1'b1;
							if (idx_inc_ok) begin
								fin_act = ACT_SET;
								fin_pos = idx_q + 16'd1;
							end
						end
					end else if (is_first) begin
						inc_d = first_diff[6:0];
						if (flag_q) begin
							if (first_diff == 8'd0) begin
								fin = 1'b1;
							end else begin
								op_we   = 1'b1;
								op_d    = OP_JUMP;
								state_d = ST_DIV_IDX;
							end
						end else if (size_q == 16'd0) begin
							fin = 1'b1;
						end else begin
							op_we   = 1'b1;
							op_d    = OP_FIRST;
							state_d = ST_DIV_IDX;
						end
					end else begin
						fin = 1'b1;
					end
				end else if (cc_hit && slot_found) begin
					if (cur_slot.role == ROLE_SELECT) begin
						fin     = 1'b1;
						last_we = 1'b1;
						fin_act = sel_fire ? ACT_SEND : ACT_NONE;
					end else if (size_q == 16'd0) begin
						fin = 1'b1;
					end else if (cur_slot.role == ROLE_PAGE) begin
						op_we   = 1'b1;
						op_d    = OP_PAGE;
						state_d = ST_DIV_MAXP;
					end else begin
						op_we   = 1'b1;
						op_d    = OP_INDEX;
						state_d = ST_MUL;
					end
				end else begin
					fin = 1'b1;
				end
			end
			ST_DIV_MAXP: begin
				div_req.start    = 1'b1;
				div_req.dividend = size_q;
				div_req.divisor  = {9'd0, ps_q};
				if (div_rsp.done) begin
					state_d = (div_rsp.quotient == 16'd0) ? ST_DIV_IDX : ST_DIV_STEP;
				end
			end
			ST_DIV_STEP: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIAL_SPAN;
				div_req.divisor  = {1'b0, maxp_q} + 17'd1;
				if (div_rsp.done) state_d = ST_DIV_VAL;
			end
			ST_DIV_VAL: begin
				div_req.start    = 1'b1;
				div_req.dividend = {9'd0, d2_q};
				div_req.divisor  = {10'd0, step_q};
				if (div_rsp.done) state_d = ST_DIV_IDX;
			end
			ST_DIV_IDX: begin
				div_req.start    = 1'b1;
				div_req.dividend = idx_q;
				div_req.divisor  = {9'd0, ps_q};
				if (div_rsp.done) state_d = ST_MUL;
			end
			ST_MUL: begin
				// stepping back from the first page goes nowhere
				if (op_q == OP_JUMP && dec_q && quo_q == 16'd0) fin = 1'b1;
				else state_d = ST_CAND;
			end
			ST_CAND: begin
				fin = 1'b1;
				if (op_q == OP_JUMP) begin
					if (cand < {9'd0, size_q}) begin
						fin_act = ACT_SET;
						fin_pos = cand[15:0];
					end
				end else begin
					fin_act = ACT_SET;
					fin_pos = (cand > {9'd0, size_m1}) ? size_m1 : cand[15:0];
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (fin) state_d = ST_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q      <= 1'b0;
			dial_page_q <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				last_q[i] <= UNDEF_CODE;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (flag_we) flag_q <= flag_d;
			if (last_we) last_q[slot_idx] <= {1'b0, d2_q};
			if (div_rsp.done) begin
				if (state_q == ST_DIV_MAXP && div_rsp.quotient == 16'd0) begin
					dial_page_q <= '0;
				end
				if (state_q == ST_DIV_VAL && op_q == OP_PAGE) begin
					dial_page_q <= (div_rsp.quotient > maxp_q) ? maxp_q : div_rsp.quotient;
				end
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) begin
			status_q <= in_ch.status_byte;
			d1_q     <= in_ch.data_one;
			d2_q     <= in_ch.data_two;
			idx_q    <= in_ch.current_position;
			size_q   <= in_ch.list_length;
			ps_q     <= (in_ch.entries_per_page == 8'd0) ? 8'd1 : in_ch.entries_per_page;
		end
		if (op_we) begin
			op_q  <= op_d;
			dec_q <= dec_d;
			inc_q <= inc_d;
		end
		if (state_q == ST_DECODE) off_q <= off_d;
		if (div_rsp.done) begin
			case (state_q)
				ST_DIV_MAXP: maxp_q <= div_rsp.quotient;
				ST_DIV_STEP: step_q <= (div_rsp.quotient == 16'd0) ? 7'd1 : div_rsp.quotient[6:0];
				ST_DIV_IDX: begin
					quo_q <= div_rsp.quotient;
					rem_q <= div_rsp.remainder[7:0];
				end
				default: ;
			endcase
		end
		if (state_q == ST_MUL) prod_q <= prod_d;
		if (fin) begin
			act_q <= fin_act;
			pos_q <= fin_pos;
		end
		if (out_load) begin
			out_act_q  <= act_q;
			out_pos_q  <= pos_q;
			out_mode_q <= flag_q;
		end
	end

	assign in_ch.ready         = (state_q == ST_IDLE);
	assign out_ch.valid        = out_valid_q;
	assign out_ch.action       = out_act_q;
	assign out_ch.new_position = out_pos_q;
	assign out_ch.paging_mode  = out_mode_q;

endmodule

@@ rtl/mlnd_checker.sv @@
// ----------------------------------------------------------------------------
// mlnd_checker - port checks for the navigation decoder
// Watches the item and result channels of the top level.
// ----------------------------------------------------------------------------
module mlnd_checker import mlnd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  out_action,
	input logic [15:0] out_new_position,
	input logic        out_paging_mode
);

	// one item in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while the previous one is in work");

	// no result rises in the cycle after an item is accepted; decode comes first
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too soon after an item");

	a_position_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_action != ACT_SET |-> out_new_position == 16'd0)
		else $error("new position set without a set-index action");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_action) &&
		$stable(out_new_position) && $stable(out_paging_mode))
		else $error("stalled result changed");

endmodule

bind midi_list_navigation_decoder_core mlnd_checker u_mlnd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_ch.valid),
	.in_ready         (in_ch.ready),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.out_action       (out_ch.action),
	.out_new_position (out_ch.new_position),
	.out_paging_mode  (out_ch.paging_mode)
);
